>>> sv/lobm_pkg.sv
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types and constants of the limit order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

   localparam int MaxOrdersDefault = 64;
   localparam int ResultCap        = 64;           // fills per message
   localparam int RcW              = $clog2(ResultCap);

   localparam logic [1:0] OP_LIMIT  = 2'd0;
   localparam logic [1:0] OP_MARKET = 2'd1;

   localparam logic SIDE_BUY  = 1'b0;
   localparam logic SIDE_SELL = 1'b1;

   localparam logic [2:0] OUT_RESTED    = 3'd0;
   localparam logic [2:0] OUT_FILLED    = 3'd1;
   localparam logic [2:0] OUT_DROPPED   = 3'd2;
   localparam logic [2:0] OUT_CANCELLED = 3'd3;
   localparam logic [2:0] OUT_UNKNOWN   = 3'd4;
   localparam logic [2:0] OUT_BOOK_FULL = 3'd5;

   typedef struct packed {
      logic [1:0]  opcode;
      logic        side;
      logic [31:0] order_ref;
      logic [31:0] limit_price;
      logic [31:0] quantity;
      logic [63:0] timestamp;
   } req_type;

   typedef struct packed {
      logic        is_trade;
      logic [31:0] buy_order_id;
      logic [31:0] sell_order_id;
      logic [31:0] trade_price;
      logic [31:0] trade_qty;
      logic [63:0] trade_time;
      logic [2:0]  outcome;
      logic [31:0] remaining_qty;
      logic [31:0] top_bid_px;
      logic [31:0] top_ask_px;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_LIMIT,
      CMD_MARKET,
      CMD_CANCEL
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         side;
      logic [31:0]  order_ref;
      logic [31:0]  price;
      logic [31:0]  quantity;
      logic [63:0]  timestamp;
   } cmd_type;

   // one result before the message outcome is known
   typedef struct packed {
      logic        is_trade;
      logic [31:0] buy_order_id;
      logic [31:0] sell_order_id;
      logic [31:0] trade_price;
      logic [31:0] trade_qty;
      logic [63:0] trade_time;
      logic [31:0] remaining_qty;
      logic [31:0] top_bid_px;
      logic [31:0] top_ask_px;
   } item_type;

   typedef struct packed {
      logic           valid;
      logic [RcW-1:0] addr;
      item_type       item;
   } item_wr_type;

   typedef struct packed {
      logic         valid;
      logic [RcW:0] count;
      logic [2:0]   outcome;
   } msg_done_type;

   typedef struct packed {
      logic        valid;
      logic        side;
      logic [31:0] order_ref;
      logic [31:0] price;
      logic [31:0] quantity;
      logic [63:0] seq;
   } slot_type;

   typedef struct packed {
      logic        found;
      logic [31:0] price;
      logic [63:0] seq;
      logic [31:0] quantity;
      logic [31:0] order_ref;
   } best_type;

endpackage

>>> sv/lobm_front.sv
// ----------------------------------------------------------------------------
// lobm_front
// Accepts request transactions, decodes the opcode and queues commands.
// ----------------------------------------------------------------------------
module lobm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  lobm_pkg::req_type req_data,
   output logic              cmd_valid,
   output lobm_pkg::cmd_type cmd,
   input  logic              cmd_pop
);

   lobm_pkg::cmd_type q_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        cnt_ff;
   logic              do_push;
   lobm_pkg::cmd_type cmd_in;

   assign full      = (cnt_ff == 2'd2);
   assign do_push   = push && !full;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      cmd_in.side      = req_data.side;
      cmd_in.order_ref = req_data.order_ref;
      cmd_in.price     = req_data.limit_price;
      cmd_in.quantity  = req_data.quantity;
      cmd_in.timestamp = req_data.timestamp;
      case (req_data.opcode)
         lobm_pkg::OP_LIMIT:  cmd_in.kind = lobm_pkg::CMD_LIMIT;
         lobm_pkg::OP_MARKET: cmd_in.kind = lobm_pkg::CMD_MARKET;
         default:             cmd_in.kind = lobm_pkg::CMD_CANCEL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (cmd_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (do_push && !cmd_pop) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (!do_push && cmd_pop) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

endmodule

>>> sv/lobm_engine.sv
// ----------------------------------------------------------------------------
// lobm_engine
// Order slot memory and match sequencer. Each pass scans all slots for the
// best bid, best ask, first free slot and cancel target, then at most one fill,
// rest or cancel is written.
// ----------------------------------------------------------------------------
module lobm_engine #(
   parameter int MAX_ORDERS = lobm_pkg::MaxOrdersDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   input  lobm_pkg::cmd_type      cmd,
   output logic                   cmd_pop,
   input  logic                   buf_busy,
   output lobm_pkg::item_wr_type  item_wr,
   output lobm_pkg::msg_done_type msg_done
);

   localparam int IdxW = $clog2(MAX_ORDERS);
   localparam int CntW = $clog2(MAX_ORDERS + 1);
   localparam logic [IdxW-1:0] LastIdx  = IdxW'(MAX_ORDERS - 1);
   localparam logic [CntW-1:0] NumSlots = CntW'(MAX_ORDERS);
   localparam logic [lobm_pkg::RcW:0] CapCount = (lobm_pkg::RcW + 1)'(lobm_pkg::ResultCap);
   localparam logic [lobm_pkg::RcW:0] OneCount = (lobm_pkg::RcW + 1)'(1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   // slot memory
   lobm_pkg::slot_type slot_mem [MAX_ORDERS];
   lobm_pkg::slot_type rd_data_ff;
   logic               mem_we;
   logic [IdxW-1:0]    mem_waddr;
   lobm_pkg::slot_type mem_wdata;
   logic [IdxW-1:0]    mem_raddr;

   state_type                 state_ff;
   logic [IdxW-1:0]           clr_cnt_ff;
   lobm_pkg::cmd_type         cmd_ff;
   logic [31:0]               rem_ff;
   logic [lobm_pkg::RcW:0]    n_ff;
   logic                      pend_ff;
   lobm_pkg::item_type        pend_item_ff;
   logic                      phase_ff;
   logic [63:0]               next_seq_ff;
   lobm_pkg::item_wr_type     item_wr_ff;
   lobm_pkg::item_wr_type     item_wr_in;
   lobm_pkg::msg_done_type    done_ff;
   lobm_pkg::msg_done_type    done_in;

   // scan bookkeeping
   logic [CntW-1:0]    issue_cnt_ff;
   logic               rd_v_ff;
   logic [IdxW-1:0]    rd_idx_ff;
   lobm_pkg::best_type best_ff [2];
   logic [IdxW-1:0]    best_idx_ff [2];
   logic               free_found_ff;
   logic [IdxW-1:0]    free_idx_ff;
   logic               hit_found_ff;
   logic [IdxW-1:0]    hit_idx_ff;
   logic [63:0]        hit_seq_ff;

   logic               scan_issue;
   logic               scan_start;
   logic               ent_better;
   logic               ent_free;
   logic               ent_hit;
   lobm_pkg::best_type eb;

   logic               is_cancel;
   logic               is_market;
   logic               opp;
   lobm_pkg::best_type ob;
   logic               price_ok;
   logic               match;
   logic               capped;
   logic               cont;
   logic               rest_now;
   logic               cancel_hit;
   logic [31:0]        fill_qty;
   logic [31:0]        left_qty;
   logic [31:0]        cur_bid;
   logic [31:0]        cur_ask;
   logic [31:0]        fin_bid;
   logic [31:0]        fin_ask;
   logic [2:0]         order_outcome;
   logic [lobm_pkg::RcW:0] n_dec;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= slot_mem[mem_raddr];
   end

   assign scan_issue = (state_ff == ST_SCAN) && (issue_cnt_ff < NumSlots);
   assign mem_raddr  = issue_cnt_ff[IdxW-1:0];
   assign cmd_pop    = (state_ff == ST_IDLE) && cmd_valid && !buf_busy && !done_ff.valid;

   // per-slot compare during the scan
   always_comb begin
      eb = best_ff[rd_data_ff.side];
      ent_better = rd_v_ff && rd_data_ff.valid &&
                   (!eb.found ||
                    ((rd_data_ff.price != eb.price) ?
                        ((rd_data_ff.side == lobm_pkg::SIDE_BUY) ? (rd_data_ff.price > eb.price)
                                                                 : (rd_data_ff.price < eb.price))
                      : (rd_data_ff.seq < eb.seq)));
      ent_free = rd_v_ff && !rd_data_ff.valid && !free_found_ff;
      ent_hit  = rd_v_ff && rd_data_ff.valid && (rd_data_ff.order_ref == cmd_ff.order_ref) &&
                 (!hit_found_ff || (rd_data_ff.seq > hit_seq_ff));
   end

   // decision after a full scan
   always_comb begin
      is_cancel = (cmd_ff.kind == lobm_pkg::CMD_CANCEL);
      is_market = (cmd_ff.kind == lobm_pkg::CMD_MARKET);
      opp       = ~cmd_ff.side;
      ob        = best_ff[opp];
      price_ok  = is_market ||
                  ((cmd_ff.side == lobm_pkg::SIDE_BUY) ? (ob.price <= cmd_ff.price)
                                                       : (ob.price >= cmd_ff.price));
      match     = (rem_ff != 32'd0) && ob.found && price_ok;
      capped    = match && (n_ff == CapCount);
      cont      = match && !capped;
      rest_now  = !match && (rem_ff != 32'd0) && !is_market && free_found_ff;
      cancel_hit = !phase_ff && hit_found_ff;
      fill_qty  = (rem_ff < ob.quantity) ? rem_ff : ob.quantity;
      left_qty  = ob.quantity - fill_qty;
      n_dec     = n_ff - OneCount;

      cur_bid = best_ff[0].found ? best_ff[0].price : 32'd0;
      cur_ask = best_ff[1].found ? best_ff[1].price : 32'd0;
      fin_bid = cur_bid;
      fin_ask = cur_ask;
      if (rest_now && cmd_ff.side == lobm_pkg::SIDE_BUY) begin
         fin_bid = (best_ff[0].found && best_ff[0].price > cmd_ff.price) ? best_ff[0].price
                                                                         : cmd_ff.price;
      end
      if (rest_now && cmd_ff.side == lobm_pkg::SIDE_SELL) begin
         fin_ask = (best_ff[1].found && best_ff[1].price < cmd_ff.price) ? best_ff[1].price
                                                                         : cmd_ff.price;
      end

      if (rem_ff == 32'd0) begin
         order_outcome = lobm_pkg::OUT_FILLED;
      end else if (capped || is_market) begin
         order_outcome = lobm_pkg::OUT_DROPPED;
      end else if (free_found_ff) begin
         order_outcome = lobm_pkg::OUT_RESTED;
      end else begin
         order_outcome = lobm_pkg::OUT_BOOK_FULL;
      end

      scan_start = cmd_pop ||
                   ((state_ff == ST_DECIDE) && (is_cancel ? cancel_hit : cont));
   end

   // result item and message completion for this decision
   always_comb begin
      item_wr_in = '0;
      done_in    = '0;
      if (state_ff == ST_DECIDE) begin
         if (is_cancel) begin
            if (!cancel_hit) begin
               item_wr_in.valid           = 1'b1;
               item_wr_in.item.top_bid_px = cur_bid;
               item_wr_in.item.top_ask_px = cur_ask;
               done_in.valid   = 1'b1;
               done_in.count   = OneCount;
               done_in.outcome = phase_ff ? lobm_pkg::OUT_CANCELLED
                                          : lobm_pkg::OUT_UNKNOWN;
            end
         end else begin
            // previous fill is reported with the book as it stands now
            if (pend_ff) begin
               item_wr_in.valid           = 1'b1;
               item_wr_in.addr            = n_dec[lobm_pkg::RcW-1:0];
               item_wr_in.item            = pend_item_ff;
               item_wr_in.item.top_bid_px = fin_bid;
               item_wr_in.item.top_ask_px = fin_ask;
            end else if (!cont) begin
               item_wr_in.valid              = 1'b1;
               item_wr_in.item.remaining_qty = rem_ff;
               item_wr_in.item.top_bid_px    = fin_bid;
               item_wr_in.item.top_ask_px    = fin_ask;
            end
            if (!cont) begin
               done_in.valid   = 1'b1;
               done_in.count   = pend_ff ? n_ff : OneCount;
               done_in.outcome = order_outcome;
            end
         end
      end
   end

   // single slot write port: clear pass, fill, rest or cancel
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_cnt_ff;
      mem_wdata = '0;
      if (state_ff == ST_CLEAR) begin
         mem_we = 1'b1;
      end else if (state_ff == ST_DECIDE) begin
         if (is_cancel) begin
            mem_we    = cancel_hit;
            mem_waddr = hit_idx_ff;
         end else if (cont) begin
            mem_we              = 1'b1;
            mem_waddr           = best_idx_ff[opp];
            mem_wdata.valid     = (left_qty != 32'd0);
            mem_wdata.side      = opp;
            mem_wdata.order_ref = ob.order_ref;
            mem_wdata.price     = ob.price;
            mem_wdata.quantity  = left_qty;
            mem_wdata.seq       = ob.seq;
         end else if (rest_now) begin
            mem_we              = 1'b1;
            mem_waddr           = free_idx_ff;
            mem_wdata.valid     = 1'b1;
            mem_wdata.side      = cmd_ff.side;
            mem_wdata.order_ref = cmd_ff.order_ref;
            mem_wdata.price     = cmd_ff.price;
            mem_wdata.quantity  = rem_ff;
            mem_wdata.seq       = next_seq_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (scan_start) begin
         issue_cnt_ff  <= '0;
         best_ff[0]    <= '0;
         best_ff[1]    <= '0;
         free_found_ff <= 1'b0;
         hit_found_ff  <= 1'b0;
      end else begin
         if (scan_issue) begin
            issue_cnt_ff <= issue_cnt_ff + CntW'(1);
         end
         if (ent_better) begin
            best_ff[rd_data_ff.side].found     <= 1'b1;
            best_ff[rd_data_ff.side].price     <= rd_data_ff.price;
            best_ff[rd_data_ff.side].seq       <= rd_data_ff.seq;
            best_ff[rd_data_ff.side].quantity  <= rd_data_ff.quantity;
            best_ff[rd_data_ff.side].order_ref <= rd_data_ff.order_ref;
            best_idx_ff[rd_data_ff.side]       <= rd_idx_ff;
         end
         if (ent_free) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= rd_idx_ff;
         end
         if (ent_hit) begin
            hit_found_ff <= 1'b1;
            hit_idx_ff   <= rd_idx_ff;
            hit_seq_ff   <= rd_data_ff.seq;
         end
      end
      rd_idx_ff <= issue_cnt_ff[IdxW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clr_cnt_ff       <= '0;
         next_seq_ff      <= 64'd0;
         rd_v_ff          <= 1'b0;
         item_wr_ff.valid <= 1'b0;
         done_ff.valid    <= 1'b0;
      end else begin
         rd_v_ff    <= scan_issue;
         item_wr_ff <= item_wr_in;
         done_ff    <= done_in;
         case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + IdxW'(1);
               if (clr_cnt_ff == LastIdx) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (cmd_pop) begin
                  cmd_ff   <= cmd;
                  rem_ff   <= cmd.quantity;
                  n_ff     <= '0;
                  pend_ff  <= 1'b0;
                  phase_ff <= 1'b0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (rd_v_ff && rd_idx_ff == LastIdx) begin
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               if (is_cancel) begin
                  if (cancel_hit) begin
                     phase_ff <= 1'b1;
                     state_ff <= ST_SCAN;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end else begin
                  if (cont) begin
                     rem_ff  <= rem_ff - fill_qty;
                     n_ff    <= n_ff + OneCount;
                     pend_ff <= 1'b1;
                     pend_item_ff.is_trade      <= 1'b1;
                     pend_item_ff.buy_order_id  <= (cmd_ff.side == lobm_pkg::SIDE_BUY) ?
                                                   cmd_ff.order_ref : ob.order_ref;
                     pend_item_ff.sell_order_id <= (cmd_ff.side == lobm_pkg::SIDE_BUY) ?
                                                   ob.order_ref : cmd_ff.order_ref;
                     pend_item_ff.trade_price   <= ob.price;
                     pend_item_ff.trade_qty     <= fill_qty;
                     pend_item_ff.trade_time    <= cmd_ff.timestamp;
                     pend_item_ff.remaining_qty <= rem_ff - fill_qty;
                     pend_item_ff.top_bid_px    <= 32'd0;
                     pend_item_ff.top_ask_px    <= 32'd0;
                     state_ff <= ST_SCAN;
                  end else begin
                     if (rest_now) begin
                        next_seq_ff <= next_seq_ff + 64'd1;
                     end
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign item_wr  = item_wr_ff;
   assign msg_done = done_ff;

endmodule

>>> sv/lobm_rsp_buf.sv
// ----------------------------------------------------------------------------
// lobm_rsp_buf
// Holds the results of one message until its outcome is known, then drains
// them in order through an output register.
// ----------------------------------------------------------------------------
module lobm_rsp_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  lobm_pkg::item_wr_type  item_wr,
   input  lobm_pkg::msg_done_type msg_done,
   output logic                   busy,
   output logic                   empty,
   input  logic                   pop,
   output lobm_pkg::rsp_type      rsp_data
);

   lobm_pkg::item_type     item_mem [lobm_pkg::ResultCap];
   lobm_pkg::item_type     rd_item_ff;
   logic                   busy_ff;
   logic [lobm_pkg::RcW:0] cnt_ff;
   logic [lobm_pkg::RcW:0] rd_ptr_ff;
   logic [lobm_pkg::RcW:0] rd_ptr_in;
   logic [2:0]             outcome_ff;
   logic                   inflight_ff;
   logic                   inflight_last_ff;
   logic                   out_valid_ff;
   lobm_pkg::rsp_type      out_data_ff;
   logic                   issue;
   logic                   out_take;

   assign out_take  = pop && out_valid_ff;
   assign issue     = busy_ff && !inflight_ff && (rd_ptr_ff < cnt_ff) &&
                      (!out_valid_ff || pop);
   assign rd_ptr_in = rd_ptr_ff + (lobm_pkg::RcW + 1)'(1);

   always_ff @(posedge clock) begin
      if (item_wr.valid) begin
         item_mem[item_wr.addr] <= item_wr.item;
      end
      rd_item_ff <= item_mem[rd_ptr_ff[lobm_pkg::RcW-1:0]];
      if (inflight_ff) begin
         out_data_ff.is_trade      <= rd_item_ff.is_trade;
         out_data_ff.buy_order_id  <= rd_item_ff.buy_order_id;
         out_data_ff.sell_order_id <= rd_item_ff.sell_order_id;
         out_data_ff.trade_price   <= rd_item_ff.trade_price;
         out_data_ff.trade_qty     <= rd_item_ff.trade_qty;
         out_data_ff.trade_time    <= rd_item_ff.trade_time;
         out_data_ff.outcome       <= outcome_ff;
         out_data_ff.remaining_qty <= rd_item_ff.remaining_qty;
         out_data_ff.top_bid_px    <= rd_item_ff.top_bid_px;
         out_data_ff.top_ask_px    <= rd_item_ff.top_ask_px;
         out_data_ff.last          <= inflight_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         inflight_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         rd_ptr_ff    <= '0;
         cnt_ff       <= '0;
      end else begin
         inflight_ff <= issue;
         if (issue) begin
            rd_ptr_ff        <= rd_ptr_in;
            inflight_last_ff <= (rd_ptr_in == cnt_ff);
         end
         if (inflight_ff) begin
            out_valid_ff <= 1'b1;
         end else if (out_take) begin
            out_valid_ff <= 1'b0;
         end
         if (msg_done.valid) begin
            busy_ff    <= 1'b1;
            cnt_ff     <= msg_done.count;
            outcome_ff <= msg_done.outcome;
            rd_ptr_ff  <= '0;
         end else if (out_take && out_data_ff.last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy     = busy_ff;
   assign empty    = !out_valid_ff;
   assign rsp_data = out_data_ff;

endmodule

>>> sv/limit_order_book_matcher.sv
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Price-time priority limit order book: limit and market orders, cancels,
// one result transaction per fill, or one status transaction when there is none.
// ----------------------------------------------------------------------------
//  channel   handshake         payload
//  request   push / full       req_data (lobm_pkg::req_type)
//  response  pop / empty       rsp_data (lobm_pkg::rsp_type)
//
// Every slot scan reads one slot a cycle.
// A new order takes (fills + 1) scans, a cancel two scans (one if unknown).
// Results then drain in order through the output register; a new result is read only once the previous read has landed.
// After reset the slot memory is cleared one slot at a time; requests queue.
// Up to two requests queue while a message is in work or results are stalled.
module limit_order_book_matcher #(
   parameter int MAX_ORDERS = lobm_pkg::MaxOrdersDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  lobm_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output lobm_pkg::rsp_type rsp_data
);

   logic                   cmd_valid;
   lobm_pkg::cmd_type      cmd;
   logic                   cmd_pop;
   logic                   buf_busy;
   lobm_pkg::item_wr_type  item_wr;
   lobm_pkg::msg_done_type msg_done;

   lobm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   lobm_engine #(
      .MAX_ORDERS (MAX_ORDERS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .buf_busy  (buf_busy),
      .item_wr   (item_wr),
      .msg_done  (msg_done)
   );

   lobm_rsp_buf u_rsp_buf (
      .clock    (clock),
      .reset    (reset),
      .item_wr  (item_wr),
      .msg_done (msg_done),
      .busy     (buf_busy),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   // the engine never writes results over a message still draining
   a_no_write_while_busy: assert property (@(posedge clock) disable iff (reset)
      item_wr.valid |-> !buf_busy)
      else $error("result written while buffer drains");

   a_trade_qty_nonzero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.is_trade) |-> (rsp_data.trade_qty != 32'd0))
      else $error("fill with zero quantity");

   a_status_zeroed: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.is_trade) |->
         (rsp_data.trade_qty == 32'd0 && rsp_data.buy_order_id == 32'd0 &&
          rsp_data.sell_order_id == 32'd0 && rsp_data.last))
      else $error("bad status transaction");

   a_rested_has_qty: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.last && rsp_data.outcome == lobm_pkg::OUT_RESTED) |->
         (rsp_data.remaining_qty != 32'd0))
      else $error("rested order with zero quantity");

endmodule

>>> sim/tb_limit_order_book_matcher.sv
// ----------------------------------------------------------------------------
// tb_limit_order_book_matcher
// Drives orders and cancels into the matcher, predicts every fill and status
// transaction with a price-time priority book model, checks all results.
// ----------------------------------------------------------------------------
module tb_limit_order_book_matcher;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Slots     = 64;
   localparam int CycleLimit = 10000000;
   localparam logic [1:0] OP_CANCEL = 2'd2;
   localparam logic [1:0] OP_ODD    = 2'd3;

   class book_scoreboard;
      logic        live [Slots];
      logic        sd   [Slots];
      logic [31:0] oid  [Slots];
      logic [31:0] px   [Slots];
      logic [31:0] qty  [Slots];
      logic [63:0] seq  [Slots];
      logic [63:0] next_seq;
      lobm_pkg::rsp_type pending [$];
      int          mismatches;
      int          fills;
      int          statuses;

      function new();
         foreach (live[i]) live[i] = 1'b0;
         next_seq   = '0;
         mismatches = 0;
         fills      = 0;
         statuses   = 0;
      endfunction

      function int top_of(logic s);
         int b;
         b = -1;
         for (int i = 0; i < Slots; i++) begin
            if (!live[i] || sd[i] != s) continue;
            if (b < 0) b = i;
            else if (px[i] != px[b]) begin
               if (s == lobm_pkg::SIDE_BUY ? px[i] > px[b] : px[i] < px[b]) b = i;
            end else if (seq[i] < seq[b]) b = i;
         end
         return b;
      endfunction

      function logic [31:0] quote(logic s);
         int b;
         b = top_of(s);
         return (b < 0) ? 32'd0 : px[b];
      endfunction

      function int count_resting();
         int n;
         n = 0;
         foreach (live[i]) if (live[i]) n++;
         return n;
      endfunction

      // predicts the transactions of one accepted message
      function void note_order(lobm_pkg::req_type r);
         lobm_pkg::rsp_type msg [$];
         lobm_pkg::rsp_type it;
         logic [31:0] left, f;
         logic [2:0]  oc;
         int          b, hit, fr;
         logic        capped;
         left   = r.quantity;
         capped = 1'b0;
         if (r.opcode >= OP_CANCEL) begin
            hit = -1;
            for (int i = 0; i < Slots; i++)
               if (live[i] && oid[i] == r.order_ref &&
                   (hit < 0 || seq[i] > seq[hit])) hit = i;
            if (hit >= 0) live[hit] = 1'b0;
            oc = (hit >= 0) ? lobm_pkg::OUT_CANCELLED : lobm_pkg::OUT_UNKNOWN;
            it = '0;
            msg.push_back(it);
         end else begin
            while (left != 0) begin
               b = top_of(~r.side);
               if (b < 0) break;
               if (r.opcode == lobm_pkg::OP_LIMIT) begin
                  if (r.side == lobm_pkg::SIDE_BUY && px[b] > r.limit_price) break;
                  if (r.side == lobm_pkg::SIDE_SELL && px[b] < r.limit_price) break;
               end
               if (msg.size() >= lobm_pkg::ResultCap) begin
                  capped = 1'b1;
                  break;
               end
               f = (left < qty[b]) ? left : qty[b];
               left   -= f;
               qty[b] -= f;
               if (qty[b] == 0) live[b] = 1'b0;
               it = '0;
               it.is_trade      = 1'b1;
               it.buy_order_id  = (r.side == lobm_pkg::SIDE_BUY) ? r.order_ref : oid[b];
               it.sell_order_id = (r.side == lobm_pkg::SIDE_BUY) ? oid[b] : r.order_ref;
               it.trade_price   = px[b];
               it.trade_qty     = f;
               it.trade_time    = r.timestamp;
               it.remaining_qty = left;
               it.top_bid_px    = quote(lobm_pkg::SIDE_BUY);
               it.top_ask_px    = quote(lobm_pkg::SIDE_SELL);
               msg.push_back(it);
            end
            if (left == 0) oc = lobm_pkg::OUT_FILLED;
            else if (capped || r.opcode == lobm_pkg::OP_MARKET) oc = lobm_pkg::OUT_DROPPED;
            else begin
               fr = -1;
               for (int i = 0; i < Slots; i++)
                  if (!live[i]) begin
                     fr = i;
                     break;
                  end
               if (fr < 0) oc = lobm_pkg::OUT_BOOK_FULL;
               else begin
                  live[fr] = 1'b1;
                  sd[fr]   = r.side;
                  oid[fr]  = r.order_ref;
                  px[fr]   = r.limit_price;
                  qty[fr]  = left;
                  seq[fr]  = next_seq;
                  next_seq++;
                  oc = lobm_pkg::OUT_RESTED;
               end
            end
            if (msg.size() == 0) begin
               it = '0;
               it.remaining_qty = left;
               msg.push_back(it);
            end
         end
         foreach (msg[k]) msg[k].outcome = oc;
         msg[$].top_bid_px = quote(lobm_pkg::SIDE_BUY);
         msg[$].top_ask_px = quote(lobm_pkg::SIDE_SELL);
         msg[$].last = 1'b1;
         foreach (msg[k]) pending.push_back(msg[k]);
      endfunction

      function void check_result(lobm_pkg::rsp_type got);
         lobm_pkg::rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transaction %p", got);
            return;
         end
         want = pending.pop_front();
         if (want.is_trade) fills++;
         else statuses++;
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch at %0t\n  expected %p\n  actual   %p", $time, want, got);
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push  = 1'b0;
   logic    pop   = 1'b0;
   logic    full, empty;
   lobm_pkg::req_type req_data = '0;
   lobm_pkg::rsp_type rsp_data;

   book_scoreboard book = new();
   int send_idle = 0;
   int recv_idle = 0;
   int cycles    = 0;
   logic [31:0] used_ids [$];
   logic [63:0] stamp = 64'd1000;

   limit_order_book_matcher dut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("limit_order_book_matcher test failed");
         $finish;
      end
   end

   // result side: sample, then choose pop for the next edge
   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty) book.check_result(rsp_data);
         pop <= ($urandom_range(99) >= recv_idle);
      end
   end

   // push stays high after an accept so the next transaction can follow at once
   task automatic send_order(lobm_pkg::req_type r);
      while ($urandom_range(99) < send_idle) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      book.note_order(r);
   endtask

   task automatic drain();
      push <= 1'b0;
      while (book.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic lobm_pkg::req_type make(logic [1:0] op, logic s, logic [31:0] id,
                                              logic [31:0] p, logic [31:0] q);
      lobm_pkg::req_type r;
      r.opcode      = op;
      r.side        = s;
      r.order_ref   = id;
      r.limit_price = p;
      r.quantity    = q;
      r.timestamp   = stamp;
      stamp += 64'($urandom_range(50, 1));
      return r;
   endfunction

   // mostly realistic orders near a mid price, some full-range noise
   task automatic random_order();
      lobm_pkg::req_type r;
      int unsigned pick;
      logic [31:0] id;
      pick = $urandom_range(99);
      id   = $urandom_range(200, 1);
      if (pick < 10) begin
         r = make(2'($urandom_range(3)), 1'($urandom_range(1)), $urandom, $urandom,
                  $urandom);
         r.timestamp = {$urandom, $urandom};
      end else if (pick < 25 && used_ids.size() != 0) begin
         r = make($urandom_range(1) ? OP_CANCEL : OP_ODD, 1'($urandom_range(1)),
                  used_ids[$urandom_range(used_ids.size() - 1)], $urandom, $urandom);
      end else if (pick < 35) begin
         r = make(lobm_pkg::OP_MARKET, 1'($urandom_range(1)), id, $urandom,
                  $urandom_range(60, 0));
      end else begin
         r = make(lobm_pkg::OP_LIMIT, 1'($urandom_range(1)), id, $urandom_range(110, 90),
                  $urandom_range(40, 1));
      end
      if (r.opcode <= lobm_pkg::OP_MARKET) used_ids.push_back(r.order_ref);
      send_order(r);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: rests, price-time fills, extremes, cancels, odd opcode
      send_order(make(lobm_pkg::OP_LIMIT, lobm_pkg::SIDE_BUY, 32'd1, 32'd0, 32'd5));
      send_order(make(lobm_pkg::OP_LIMIT, lobm_pkg::SIDE_BUY, 32'd2, 32'd100, 32'd10));
      send_order(make(lobm_pkg::OP_LIMIT, lobm_pkg::SIDE_BUY, 32'd3, 32'd100, 32'd10));
      send_order(make(lobm_pkg::OP_LIMIT, lobm_pkg::SIDE_SELL, 32'd4, 32'hFFFF_FFFF, 32'd7));
      send_order(make(lobm_pkg::OP_LIMIT, lobm_pkg::SIDE_SELL, 32'd5, 32'd90, 32'd15));
      send_order(make(lobm_pkg::OP_LIMIT, lobm_pkg::SIDE_BUY, 32'hFFFF_FFFF, 32'd0, 32'd0));
      send_order(make(lobm_pkg::OP_MARKET, lobm_pkg::SIDE_SELL, 32'd6, 32'd0, 32'd0));
      send_order(make(lobm_pkg::OP_MARKET, lobm_pkg::SIDE_BUY, 32'd7, 32'd0, 32'hFFFF_FFFF));
      send_order(make(lobm_pkg::OP_LIMIT, lobm_pkg::SIDE_SELL, 32'd8, 32'd50, 32'd2));
      send_order(make(lobm_pkg::OP_LIMIT, lobm_pkg::SIDE_SELL, 32'd9, 32'd50, 32'd2));
      send_order(make(lobm_pkg::OP_LIMIT, lobm_pkg::SIDE_SELL, 32'd9, 32'd51, 32'd2));
      send_order(make(OP_CANCEL, lobm_pkg::SIDE_BUY, 32'd9, 32'd0, 32'd0));
      send_order(make(OP_ODD, lobm_pkg::SIDE_SELL, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_order(make(OP_CANCEL, lobm_pkg::SIDE_SELL, 32'd12345, 32'd0, 32'd0));
      send_order(make(lobm_pkg::OP_MARKET, lobm_pkg::SIDE_SELL, 32'd10, 32'd0,
                      32'hFFFF_FFFF));
      begin
         lobm_pkg::req_type r;
         r = make(lobm_pkg::OP_LIMIT, lobm_pkg::SIDE_BUY, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);
         r.timestamp = '1;
         send_order(r);
      end
      drain();

      // book-full: fill every slot with non-crossing asks, then overflow
      send_order(make(lobm_pkg::OP_MARKET, lobm_pkg::SIDE_SELL, 32'd11, 32'd0,
                      32'hFFFF_FFFF));
      while (book.count_resting() < Slots)
         send_order(make(lobm_pkg::OP_LIMIT, lobm_pkg::SIDE_SELL,
                         32'd500 + book.count_resting(),
                         32'd1000 + $urandom_range(20), 32'd1));
      send_order(make(lobm_pkg::OP_LIMIT, lobm_pkg::SIDE_SELL, 32'd600, 32'd2000, 32'd3));
      send_order(make(lobm_pkg::OP_LIMIT, lobm_pkg::SIDE_BUY, 32'd601, 32'd10, 32'd3));
      // sweep the whole book in one message: 64 fills
      send_order(make(lobm_pkg::OP_MARKET, lobm_pkg::SIDE_BUY, 32'd602, 32'd0, 32'd100));
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 47 : 27) : 0;
         recv_idle = (ph == 2 || ph == 3) ? (ph == 2 ? 47 : 27) : 0;
         repeat (16) random_order();
         drain();
      end

      $display("covered %0d fills and %0d status transactions, book-full and 64-fill sweep",
               book.fills, book.statuses);
      if (book.mismatches == 0 && book.pending.size() == 0)
         $display("limit_order_book_matcher test passed");
      else
         $display("limit_order_book_matcher test failed");
      $finish;
   end
endmodule
